### hdl/rht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types and constants for the reference-counted handle table: request
// and response transaction payloads, operation codes, entry layout and the
// name canonicalisation function.
// ----------------------------------------------------------------------------
package rht_pkg;

  // field widths fixed by the transaction format
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 8;
  localparam int TYPE_W   = 4;
  localparam int NAME_W   = 64;
  localparam int BODY_W   = 32;
  localparam int REFS_W   = 16;
  localparam int HOUT_W   = 6;
  localparam int LIVE_W   = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_REF    = 2'd1;
  localparam logic [OP_W-1:0] OP_DEREF  = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

  // status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [TYPE_W-1:0]   obj_type;
    logic [NAME_W-1:0]   name_key;
    logic                name_present;
    logic [BODY_W-1:0]   body_tag;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [HOUT_W-1:0]   handle_out;
    logic [BODY_W-1:0]   body_out;
    logic                released;
    logic [LIVE_W-1:0]   live_count;
  } rsp_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [TYPE_W-1:0] obj_type;
    logic [NAME_W-1:0] name;
    logic [BODY_W-1:0] body;
    logic [REFS_W-1:0] refs;
  } entry_t;

  // a name ends at its first zero byte; every later byte reads as zero
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] key);
    logic              alive;
    logic [NAME_W-1:0] res;
    alive = 1'b1;
    res   = '0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      alive = alive & (key[8*i +: 8] != 8'd0);
      res[8*i +: 8] = alive ? key[8*i +: 8] : 8'd0;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hdl/rht_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rht_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rht_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

### hdl/refcounted_handle_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_handle_table_top
// Reference-counted handle table: create, reference, dereference and find by
// name over SLOTS entries held in a single-port-read entry memory.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time and gives one response
// transaction. Reference and dereference read the entry, then do a
// read-modify-write of the count, then load the response register. Create
// walks the valid bits one slot per cycle from slot 0 until it finds the
// lowest free slot or reaches the last one. Find streams the entries through
// the one read port of the entry memory one slot per cycle until the first
// match or the last slot; find without a name skips the scan. Valid bits
// live in flip-flops cleared by reset, so no clearing pass follows reset. A
// new request is taken once the previous result sits in the response
// register, even if it has not yet been taken.
// ----------------------------------------------------------------------------
module refcounted_handle_table_top #(
  parameter int SLOTS      = 64,
  parameter int NAME_BYTES = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  rht_chan_if.sink   req,
  rht_chan_if.source rsp
);
  import rht_pkg::*;

  localparam int IDXW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [HANDLE_W:0] SLOTS_H  = (HANDLE_W + 1)'(SLOTS);
  localparam logic [IDXW-1:0]   LAST_IDX = IDXW'(SLOTS - 1);
  localparam logic [NAME_W-1:0] NAME_MASK =
    (64'd1 << (8 * (NAME_BYTES - 1))) - 64'd1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRT  = 3'd1;
  localparam logic [2:0] S_FND  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;

  // control state
  logic [2:0]       state;
  logic [SLOTS-1:0] valid;
  logic [CNT_W-1:0] count;
  logic [IDXW-1:0]  scan_idx;
  logic [IDXW-1:0]  cmp_idx;
  logic             issue_done;
  logic             rd_pend;
  logic             out_valid;

  // request and result registers
  logic [OP_W-1:0]   op_r;
  logic [IDXW-1:0]   idx_r;
  logic              hok_r;
  logic [TYPE_W-1:0] typ_r;
  logic [NAME_W-1:0] key_r;
  logic              present_r;
  logic [BODY_W-1:0] body_r;
  logic              res_status;
  logic [IDXW-1:0]   res_idx;
  logic [BODY_W-1:0] res_body;
  logic              res_rel;
  rsp_t              out_pl;

  // entry memory
  entry_t          mem [SLOTS];
  entry_t          rd_data;
  logic [IDXW-1:0] rd_addr;
  logic            mem_we;
  logic [IDXW-1:0] mem_wa;
  entry_t          mem_wd;

  logic              accept;
  logic              out_free;
  logic              upd_ok;
  logic              find_hit;
  logic [REFS_W-1:0] refs_next;

  assign accept    = req.valid && (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.payload = out_pl;

  assign upd_ok   = hok_r && valid[idx_r];
  assign find_hit = valid[cmp_idx] && (rd_data.obj_type == typ_r) && (rd_data.name == key_r);

  // read address: handle at acceptance, scan pointer otherwise
  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = req.payload.handle[IDXW-1:0];
    end else begin
      rd_addr = scan_idx;
    end
  end

  // new reference count for reference or dereference
  always_comb begin
    if (op_r == OP_REF) begin
      refs_next = (rd_data.refs == REFS_MAX) ? rd_data.refs : rd_data.refs + REFS_W'(1);
    end else begin
      refs_next = rd_data.refs - REFS_W'(1);
    end
  end

  // write port: new entry on create, count update on reference or dereference
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = rd_data;
    if ((state == S_CRT) && !valid[scan_idx]) begin
      mem_we          = 1'b1;
      mem_wa          = scan_idx;
      mem_wd.obj_type = typ_r;
      mem_wd.name     = present_r ? (key_r & NAME_MASK) : '0;
      mem_wd.body     = body_r;
      mem_wd.refs     = REFS_W'(1);
    end else if ((state == S_UPD) && upd_ok) begin
      mem_we      = 1'b1;
      mem_wd.refs = refs_next;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= '0;
      count      <= '0;
      scan_idx   <= '0;
      cmp_idx    <= '0;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // response taken; a new one is loaded only from the post state
      if (rsp.ready && (state != S_POST)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r       <= req.payload.op;
            idx_r      <= req.payload.handle[IDXW-1:0];
            hok_r      <= ((HANDLE_W + 1)'(req.payload.handle) < SLOTS_H);
            typ_r      <= req.payload.obj_type;
            key_r      <= canon_name(req.payload.name_key);
            present_r  <= req.payload.name_present;
            body_r     <= req.payload.body_tag;
            scan_idx   <= '0;
            issue_done <= 1'b0;
            rd_pend    <= 1'b0;
            res_status <= ST_FAIL;
            res_idx    <= '0;
            res_body   <= '0;
            res_rel    <= 1'b0;
            case (req.payload.op)
              OP_CREATE: state <= S_CRT;
              OP_REF:    state <= S_UPD;
              OP_DEREF:  state <= S_UPD;
              OP_FIND:   state <= req.payload.name_present ? S_FND : S_POST;
              default:   state <= S_POST;
            endcase
          end
        end

        // walk valid bits for the lowest free slot
        S_CRT: begin
          if (!valid[scan_idx]) begin
            valid[scan_idx] <= 1'b1;
            count           <= count + CNT_W'(1);
            res_status      <= ST_OK;
            res_idx         <= scan_idx;
            state           <= S_POST;
          end else if (scan_idx == LAST_IDX) begin
            state <= S_POST;
          end else begin
            scan_idx <= scan_idx + IDXW'(1);
          end
        end

        // stream entries through the read port, compare in the cycle after each read
        S_FND: begin
          rd_pend <= !issue_done;
          if (!issue_done) begin
            cmp_idx <= scan_idx;
            if (scan_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + IDXW'(1);
            end
          end
          if (rd_pend) begin
            if (find_hit) begin
              res_status <= ST_OK;
              res_idx    <= cmp_idx;
              state      <= S_POST;
            end else if (cmp_idx == LAST_IDX) begin
              state <= S_POST;
            end
          end
        end

        // read-modify-write of the reference count
        S_UPD: begin
          if (upd_ok) begin
            res_status <= ST_OK;
            if (op_r == OP_REF) begin
              res_body <= rd_data.body;
            end else if (rd_data.refs == REFS_W'(1)) begin
              valid[idx_r] <= 1'b0;
              count        <= count - CNT_W'(1);
              res_body     <= rd_data.body;
              res_rel      <= 1'b1;
            end
          end
          state <= S_POST;
        end

        // hand the result to the response register
        S_POST: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if ((state == S_POST) && out_free) begin
      out_pl.status     <= res_status;
      out_pl.handle_out <= HOUT_W'(res_idx);
      out_pl.body_out   <= res_body;
      out_pl.released   <= res_rel;
      out_pl.live_count <= LIVE_W'(count);
    end
  end

endmodule
`default_nettype wire
